>>> rtl/core/msel_pkg.sv
// Shared types and constants of the multi-link best selector.
package msel_pkg;

    localparam int unsigned METRIC_W = 16;
    localparam int unsigned LOSS_W   = 10;
    localparam int unsigned SCORE_W  = 22;
    localparam int unsigned ID_W     = 4;
    localparam int unsigned WEIGHT_W = 8;
    localparam int unsigned QUOT_W   = 10;  // normalized scores reach at most 1000
    localparam int unsigned NUM_W    = 26;  // 1000 times a 16-bit difference

    localparam logic [1:0] ALG_LOWEST_RTT  = 2'd0;
    localparam logic [1:0] ALG_WEIGHTED    = 2'd1;
    localparam logic [1:0] ALG_SECURE_1ST  = 2'd2;
    localparam logic [1:0] ALG_THRESHOLD   = 2'd3;

    localparam logic [1:0] POLICY_OFF      = 2'd0;
    localparam logic [1:0] POLICY_PREFER   = 2'd1;
    localparam logic [1:0] POLICY_REQUIRED = 2'd2;

    localparam logic [1:0] LINK_UP         = 2'd0;
    localparam logic [1:0] LINK_DEGRADED   = 2'd1;
    localparam logic [1:0] LINK_DOWN       = 2'd2;

    localparam logic [2:0] REG_ALGORITHM   = 3'd0;
    localparam logic [2:0] REG_POLICY      = 3'd1;
    localparam logic [2:0] REG_RTT_THR     = 3'd2;
    localparam logic [2:0] REG_JIT_THR     = 3'd3;
    localparam logic [2:0] REG_LOSS_THR    = 3'd4;
    localparam logic [2:0] REG_LIMITS      = 3'd5;
    localparam logic [2:0] REG_WEIGHTS     = 3'd6;

    // One finished record handed to the running-best tracker.
    typedef struct packed {
        logic [ID_W-1:0]           link_id;
        logic                      basic;
        logic                      secure;
        logic                      allowed;
        logic                      thr_ok;
        logic [METRIC_W-1:0]       rtt;
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                algorithm;
        logic [1:0]                policy;
        logic                      last;
    } upd_t;

    // Selection formed when a set closes.
    typedef struct packed {
        logic                      found;
        logic [ID_W-1:0]           link;
        logic signed [SCORE_W-1:0] score;
    } res_t;

endpackage

>>> rtl/core/multi_link_best_selector.sv
// Top level of the multi-link best selector: configuration, sequencer and score unit.
//
// Link records enter on the s_ stream, one record per request; s_tlast marks the
// final record of a set. When that record has been scored, one selection leaves
// on the m_ stream: a found flag, the chosen link id and its score. Records that
// are not last produce no output request. Configuration registers are written
// through cfg_we / cfg_index / cfg_wdata and must only change while the block is idle.
//
// An ineligible record, or any record in lowest-latency mode, goes from acceptance
// straight to the commit step, and the next request is taken once it is committed.
// A weighted record runs its three normalized metrics through one shared restoring
// divider (bypassed when the maximum is zero or the metric reaches it) and one 10x8
// multiply-accumulate, then adds the signal and security terms and takes off the
// degraded penalty; a new request is taken only once the record is committed.
// s_tready is high only while the sequencer is idle. The selection sits in an output
// register, so the next set can start while the receiver stalls; if another set
// closes first, the sequencer holds at its final step until m_tready frees it.
// Reset (synchronous, aresetn low) restores the register defaults, clears the
// running best and drops any pending selection.
module multi_link_best_selector #(
    parameter int unsigned MAX_LINKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Link records: link_id[3:0], enabled[4], link_state[6:5], measurement_ok[7],
    // secure[8], rtt_ms[24:9], jitter[40:25], loss[50:41],
    // rssi[58:51], zero fill above.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    // Selections: found[0], chosen_link[4:1], chosen_score[26:5], zero fill above.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Register write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    localparam int unsigned MW = msel_pkg::METRIC_W;
    localparam int unsigned SW = msel_pkg::SCORE_W;
    localparam int unsigned PROD_W = msel_pkg::QUOT_W + msel_pkg::WEIGHT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DIV, S_MAC, S_SIG, S_SEC, S_COMMIT
    } state_t;

    // Configuration registers.
    logic [1:0]            alg_reg;
    logic [1:0]            policy_reg;
    logic [MW-1:0]         rtt_thr_reg;
    logic [MW-1:0]         jit_thr_reg;
    logic [msel_pkg::LOSS_W-1:0] loss_thr_reg;
    logic [47:0]           limits_reg;
    logic [39:0]           weights_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_reg      <= msel_pkg::ALG_WEIGHTED;
            policy_reg   <= msel_pkg::POLICY_OFF;
            rtt_thr_reg  <= '1;
            jit_thr_reg  <= '1;
            loss_thr_reg <= '1;
            limits_reg   <= '0;
            weights_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                msel_pkg::REG_ALGORITHM: alg_reg      <= cfg_wdata[1:0];
                msel_pkg::REG_POLICY:    policy_reg   <= cfg_wdata[1:0];
                msel_pkg::REG_RTT_THR:   rtt_thr_reg  <= cfg_wdata[MW-1:0];
                msel_pkg::REG_JIT_THR:   jit_thr_reg  <= cfg_wdata[MW-1:0];
                msel_pkg::REG_LOSS_THR:  loss_thr_reg <= cfg_wdata[msel_pkg::LOSS_W-1:0];
                msel_pkg::REG_LIMITS:    limits_reg   <= cfg_wdata;
                msel_pkg::REG_WEIGHTS:   weights_reg  <= cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    // Captured record fields.
    logic [msel_pkg::ID_W-1:0]   id_reg;
    logic [1:0]                  lstate_reg;
    logic                        basic_reg;
    logic                        sec_reg;
    logic [MW-1:0]               rtt_reg;
    logic [MW-1:0]               jit_reg;
    logic [msel_pkg::LOSS_W-1:0] loss_reg;
    logic signed [7:0]           dbm_reg;
    logic                        last_reg;

    // Sequencer and score unit.
    state_t                      state_reg;
    logic [1:0]                  idx_reg;
    logic signed [SW-1:0]        acc_reg;
    logic [msel_pkg::QUOT_W-1:0] quot_reg;
    logic                        m_tvalid_reg;
    msel_pkg::res_t              m_res_reg;

    logic                        in_fire;
    logic                        in_basic;
    logic [MW-1:0]               x_sel;
    logic [MW-1:0]               m_sel;
    logic [7:0]                  w_sel;
    logic                        skip_div;
    logic [MW-1:0]               diff;
    logic [msel_pkg::NUM_W-1:0]  dividend;
    logic                        div_start;
    logic                        div_done;
    logic [msel_pkg::QUOT_W-1:0] div_quot;
    logic [PROD_W-1:0]           mac_prod;
    logic [5:0]                  sig_off;
    logic [9:0]                  sig_score;
    logic [PROD_W-1:0]           sig_prod;
    logic [PROD_W-1:0]           sec_bonus;
    logic signed [SW-1:0]        penalty;
    logic                        commit_block;
    logic                        upd_valid;
    msel_pkg::upd_t              upd;
    msel_pkg::res_t              res;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_basic = s_tdata[4] && (s_tdata[6:5] != msel_pkg::LINK_DOWN) && s_tdata[7];

    // Metric, maximum and weight of the term being normalized.
    always_comb begin
        unique case (idx_reg)
            2'd0: begin
                x_sel = rtt_reg;
                m_sel = limits_reg[15:0];
                w_sel = weights_reg[7:0];
            end
            2'd1: begin
                x_sel = jit_reg;
                m_sel = limits_reg[31:16];
                w_sel = weights_reg[15:8];
            end
            2'd2: begin
                x_sel = MW'(loss_reg);
                m_sel = limits_reg[47:32];
                w_sel = weights_reg[23:16];
            end
            default: begin
                x_sel = '0;
                m_sel = '0;
                w_sel = '0;
            end
        endcase
    end

    assign skip_div  = (m_sel == '0) || (x_sel >= m_sel);
    assign diff      = m_sel - x_sel;
    assign dividend  = msel_pkg::NUM_W'(diff) * msel_pkg::NUM_W'(1000);
    assign div_start = (state_reg == S_PREP) && !skip_div;
    assign mac_prod  = PROD_W'(quot_reg) * PROD_W'(w_sel);

    // Signal term: full credit at -50 dBm and above, none at -100 dBm and below.
    always_comb begin
        sig_off = 6'(dbm_reg + 8'sd100);
        if (dbm_reg >= -8'sd50) begin
            sig_score = 10'd1000;
        end else if (dbm_reg <= -8'sd100) begin
            sig_score = '0;
        end else begin
            sig_score = {sig_off, 4'b0} + {2'b0, sig_off, 2'b0};
        end
    end

    assign sig_prod  = PROD_W'(sig_score) * PROD_W'(weights_reg[31:24]);
    assign sec_bonus = sec_reg ? PROD_W'(weights_reg[39:32]) * PROD_W'(1000) : '0;
    assign penalty   = (lstate_reg == msel_pkg::LINK_DEGRADED) ? SW'(500) : '0;

    msel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (m_sel),
        .done     (div_done),
        .quotient (div_quot)
    );

    // A closing record waits while a previous selection is still unread.
    assign commit_block = last_reg && m_tvalid_reg && !m_tready;
    assign upd_valid    = (state_reg == S_COMMIT) && !commit_block;

    always_comb begin
        upd.link_id   = id_reg;
        upd.basic     = basic_reg;
        upd.secure    = sec_reg;
        upd.allowed   = (policy_reg == msel_pkg::POLICY_REQUIRED) ? sec_reg : 1'b1;
        upd.thr_ok    = (rtt_reg <= rtt_thr_reg) && (jit_reg <= jit_thr_reg) &&
                        (loss_reg <= loss_thr_reg);
        upd.rtt       = rtt_reg;
        upd.score     = acc_reg;
        upd.algorithm = alg_reg;
        upd.policy    = policy_reg;
        upd.last      = last_reg;
    end

    msel_best #(
        .MAX_LINKS (MAX_LINKS)
    ) u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_valid (upd_valid),
        .upd       (upd),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A closing record loads the output register; otherwise a taken
            // selection empties it.
            if (upd_valid && last_reg) begin
                m_tvalid_reg <= 1'b1;
                m_res_reg    <= res;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        id_reg     <= s_tdata[3:0];
                        lstate_reg <= s_tdata[6:5];
                        sec_reg    <= s_tdata[8];
                        rtt_reg    <= s_tdata[24:9];
                        jit_reg    <= s_tdata[40:25];
                        loss_reg   <= s_tdata[50:41];
                        dbm_reg    <= s_tdata[58:51];
                        last_reg   <= s_tlast;
                        basic_reg  <= in_basic;
                        acc_reg    <= '0;
                        idx_reg    <= '0;
                        // Scoring is only needed for eligible records in the weighted modes.
                        if (in_basic && alg_reg != msel_pkg::ALG_LOWEST_RTT) begin
                            state_reg <= S_PREP;
                        end else begin
                            state_reg <= S_COMMIT;
                        end
                    end
                end
                S_PREP: begin
                    if (skip_div) begin
                        quot_reg  <= '0;
                        state_reg <= S_MAC;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        quot_reg  <= div_quot;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    acc_reg <= acc_reg + $signed({{(SW-PROD_W){1'b0}}, mac_prod});
                    if (idx_reg == 2'd2) begin
                        state_reg <= S_SIG;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_PREP;
                    end
                end
                S_SIG: begin
                    acc_reg   <= acc_reg + $signed({{(SW-PROD_W){1'b0}}, sig_prod});
                    state_reg <= S_SEC;
                end
                S_SEC: begin
                    acc_reg   <= acc_reg + $signed({{(SW-PROD_W){1'b0}}, sec_bonus})
                                 - penalty;
                    state_reg <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (!commit_block) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_res_reg.score, m_res_reg.link, m_res_reg.found};

endmodule

>>> rtl/core/msel_div.sv
// Restoring divider, one quotient bit per cycle, for the normalized metric scores.
module msel_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [msel_pkg::NUM_W-1:0]    dividend,
    input  logic [msel_pkg::METRIC_W-1:0] divisor,
    output logic                          done,
    output logic [msel_pkg::QUOT_W-1:0]   quotient
);

    localparam int unsigned SH_W  = msel_pkg::METRIC_W + msel_pkg::QUOT_W - 1;
    localparam int unsigned CNT_W = $clog2(msel_pkg::QUOT_W);

    logic [msel_pkg::NUM_W-1:0]  rem_reg;
    logic [SH_W-1:0]             sh_reg;
    logic [msel_pkg::QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [msel_pkg::NUM_W-1:0]  sh_ext;
    logic                        fits;

    // The caller guarantees dividend < divisor * 2**QUOT_W.
    assign sh_ext = msel_pkg::NUM_W'(sh_reg);
    assign fits   = rem_reg >= sh_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(msel_pkg::QUOT_W - 1);
                rem_reg  <= dividend;
                sh_reg   <= {divisor, {(msel_pkg::QUOT_W-1){1'b0}}};
                quot_reg <= '0;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= rem_reg - sh_ext;
                end
                quot_reg <= {quot_reg[msel_pkg::QUOT_W-2:0], fits};
                sh_reg   <= sh_reg >> 1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/core/msel_best.sv
// Running best and secure-best tracker with set closing and result forming.
module msel_best #(
    parameter int unsigned MAX_LINKS = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            upd_valid,
    input  msel_pkg::upd_t  upd,
    output msel_pkg::res_t  res
);

    localparam int unsigned CNT_W = $clog2(MAX_LINKS + 1);

    logic                                  best_valid_reg, best_valid_next;
    logic [msel_pkg::ID_W-1:0]             best_link_reg, best_link_next;
    logic signed [msel_pkg::SCORE_W-1:0]   best_score_reg, best_score_next;
    logic [msel_pkg::METRIC_W:0]           best_rtt_reg, best_rtt_next;
    logic                                  sec_valid_reg, sec_valid_next;
    logic [msel_pkg::ID_W-1:0]             sec_link_reg, sec_link_next;
    logic signed [msel_pkg::SCORE_W-1:0]   sec_score_reg, sec_score_next;
    logic [CNT_W-1:0]                      seen_reg, seen_next;
    logic                                  too_many_reg, too_many_next;

    always_comb begin
        best_valid_next = best_valid_reg;
        best_link_next  = best_link_reg;
        best_score_next = best_score_reg;
        best_rtt_next   = best_rtt_reg;
        sec_valid_next  = sec_valid_reg;
        sec_link_next   = sec_link_reg;
        sec_score_next  = sec_score_reg;
        seen_next       = seen_reg;
        too_many_next   = too_many_reg;

        if (seen_reg >= CNT_W'(MAX_LINKS)) begin
            too_many_next = 1'b1;
        end else begin
            seen_next = seen_reg + 1'b1;
        end

        if (upd.basic) begin
            if (upd.algorithm == msel_pkg::ALG_LOWEST_RTT) begin
                if (upd.allowed && ({1'b0, upd.rtt} < best_rtt_reg)) begin
                    best_rtt_next   = {1'b0, upd.rtt};
                    best_valid_next = 1'b1;
                    best_link_next  = upd.link_id;
                    best_score_next = 22'sd100000 - $signed({6'b0, upd.rtt});
                end
            end else begin
                if (upd.algorithm == msel_pkg::ALG_SECURE_1ST && upd.secure &&
                    (!sec_valid_reg || upd.score > sec_score_reg)) begin
                    sec_valid_next = 1'b1;
                    sec_link_next  = upd.link_id;
                    sec_score_next = upd.score;
                end
                if (upd.allowed &&
                    (upd.algorithm != msel_pkg::ALG_THRESHOLD || upd.thr_ok) &&
                    (!best_valid_reg || upd.score > best_score_reg)) begin
                    best_valid_next = 1'b1;
                    best_link_next  = upd.link_id;
                    best_score_next = upd.score;
                end
            end
        end

        // The selection reflects the state after this record.
        res = '0;
        if (!too_many_next) begin
            if (upd.algorithm == msel_pkg::ALG_SECURE_1ST && sec_valid_next) begin
                res.found = 1'b1;
                res.link  = sec_link_next;
                res.score = sec_score_next;
            end else if (upd.algorithm == msel_pkg::ALG_SECURE_1ST &&
                         upd.policy == msel_pkg::POLICY_REQUIRED) begin
                res = '0;
            end else if (best_valid_next) begin
                res.found = 1'b1;
                res.link  = best_link_next;
                res.score = best_score_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (upd_valid && upd.last)) begin
            best_valid_reg <= 1'b0;
            best_link_reg  <= '0;
            best_score_reg <= '0;
            best_rtt_reg   <= '1;
            sec_valid_reg  <= 1'b0;
            sec_link_reg   <= '0;
            sec_score_reg  <= '0;
            seen_reg       <= '0;
            too_many_reg   <= 1'b0;
        end else if (upd_valid) begin
            best_valid_reg <= best_valid_next;
            best_link_reg  <= best_link_next;
            best_score_reg <= best_score_next;
            best_rtt_reg   <= best_rtt_next;
            sec_valid_reg  <= sec_valid_next;
            sec_link_reg   <= sec_link_next;
            sec_score_reg  <= sec_score_next;
            seen_reg       <= seen_next;
            too_many_reg   <= too_many_next;
        end
    end

endmodule

>>> bench/tb_multi_link_best_selector.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-link best selector, with a running selection predictor.
module tb_multi_link_best_selector;

    localparam int unsigned MAX_LINKS   = 8;
    // Quiet cycles waited after the last expected selection; enough to guarantee
    // that nothing is still being scored.
    localparam int          SETTLE      = 80;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          ITEM_TARGET = 1550;

    // One link record as the sender sees it.
    typedef struct {
        logic [3:0]        id;
        logic              en;
        logic [1:0]        lstate;
        logic              meas;
        logic              sec;
        logic [15:0]       rtt;
        logic [15:0]       jit;
        logic [9:0]        loss;
        logic signed [7:0] dbm;
        logic              last;
    } link_rec_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;

    // Shadow copy of the register file, updated on every write.
    logic [1:0]  cfg_algorithm;
    logic [1:0]  cfg_policy;
    logic [15:0] cfg_rtt_thr;
    logic [15:0] cfg_jit_thr;
    logic [9:0]  cfg_loss_thr;
    logic [47:0] cfg_limits;
    logic [39:0] cfg_weights;

    // Running best of the set currently being collected.
    logic        run_valid;
    logic [3:0]  run_link;
    int          run_score;
    logic [16:0] run_best_rtt;
    logic        sec_valid;
    logic [3:0]  sec_link;
    int          sec_score;
    int unsigned run_count;
    logic        run_overflow;

    msel_pkg::res_t pending_selections[$];

    int          records_sent;
    int          selections_checked;
    int          selections_found;
    int          oversize_sets;
    int          settings_written;
    int          mismatch_count;
    int          cycle_count;
    int          rx_hold_len;
    int          rx_stall;
    bit          no_idle;

    multi_link_best_selector #(
        .MAX_LINKS(MAX_LINKS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // id[3:0] en[4] state[6:5] meas[7] sec[8] rtt[24:9]
                               // jitter[40:25] loss[50:41] dbm[58:51], zero fill above
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // found[0] link[4:1] score[26:5], zero fill above
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always #2 aclk = ~aclk;

    // Global watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d selections still expected",
                     $realtime, cycle_count, pending_selections.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int random_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Receiver. A long hold requested by a test is counted down here; otherwise
    // m_tready follows random stall lengths, or stays high in no-idle stretches.
    initial begin
        m_tready = 1'b0;
        rx_stall = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                m_tready = 1'b0;
                rx_hold_len--;
            end else if (no_idle) begin
                m_tready = 1'b1;
            end else if (rx_stall > 0) begin
                m_tready = 1'b0;
                rx_stall--;
            end else begin
                rx_stall = random_gap();
                m_tready = (rx_stall == 0);
                if (rx_stall > 0) rx_stall--;
            end
        end
    end

    // Normalized metric: 1000 at zero, falling linearly to 0 at the maximum; 0 when the maximum is zero.
    function automatic int norm_metric(input int unsigned x, input int unsigned m);
        if (m == 0 || x >= m) return 0;
        return int'((1000 * (m - x)) / m);
    endfunction

    function automatic int weighted_link_score(input link_rec_t r);
        int w_rtt;
        int w_jit;
        int w_loss;
        int w_sig;
        int w_sec;
        int dbm;
        int sig;
        int s;
        w_rtt  = int'(cfg_weights[7:0]);
        w_jit  = int'(cfg_weights[15:8]);
        w_loss = int'(cfg_weights[23:16]);
        w_sig  = int'(cfg_weights[31:24]);
        w_sec  = int'(cfg_weights[39:32]);
        dbm    = int'(r.dbm);
        if (dbm >= -50)
            sig = 1000;
        else if (dbm <= -100)
            sig = 0;
        else
            sig = (dbm + 100) * 20;
        s = norm_metric(32'(r.rtt), 32'(cfg_limits[15:0])) * w_rtt
          + norm_metric(32'(r.jit), 32'(cfg_limits[31:16])) * w_jit
          + norm_metric(32'(r.loss), 32'(cfg_limits[47:32])) * w_loss
          + sig * w_sig;
        if (r.sec) s += 1000 * w_sec;
        if (r.lstate == msel_pkg::LINK_DEGRADED) s -= 500;
        return s;
    endfunction

    function automatic void clear_running_best();
        run_valid    = 1'b0;
        run_link     = '0;
        run_score    = 0;
        run_best_rtt = '1;
        sec_valid    = 1'b0;
        sec_link     = '0;
        sec_score    = 0;
        run_count    = 0;
        run_overflow = 1'b0;
    endfunction

    // Folds one accepted record into the running best and, on the last record
    // of a set, queues the selection that the block must produce.
    function automatic void track_link_record(input link_rec_t r);
        logic basic;
        logic allowed;
        logic thr_ok;
        int   s;
        msel_pkg::res_t sel;
        basic   = r.en && (r.lstate != msel_pkg::LINK_DOWN) && r.meas;
        allowed = (cfg_policy == msel_pkg::POLICY_REQUIRED) ? r.sec : 1'b1;
        if (run_count >= MAX_LINKS)
            run_overflow = 1'b1;
        else
            run_count++;
        if (basic) begin
            s = weighted_link_score(r);
            if (cfg_algorithm == msel_pkg::ALG_LOWEST_RTT) begin
                // Strictly smaller round trip only, so the earlier link keeps a tie.
                if (allowed && {1'b0, r.rtt} < run_best_rtt) begin
                    run_best_rtt = {1'b0, r.rtt};
                    run_valid    = 1'b1;
                    run_link     = r.id;
                    run_score    = 100000 - int'(r.rtt);
                end
            end else begin
                thr_ok = (r.rtt <= cfg_rtt_thr) && (r.jit <= cfg_jit_thr) &&
                         (r.loss <= cfg_loss_thr);
                if (cfg_algorithm == msel_pkg::ALG_SECURE_1ST && r.sec &&
                    (!sec_valid || s > sec_score)) begin
                    sec_valid = 1'b1;
                    sec_link  = r.id;
                    sec_score = s;
                end
                if (allowed && (cfg_algorithm != msel_pkg::ALG_THRESHOLD || thr_ok) &&
                    (!run_valid || s > run_score)) begin
                    run_valid = 1'b1;
                    run_link  = r.id;
                    run_score = s;
                end
            end
        end
        if (r.last) begin
            sel = '0;
            if (run_overflow) begin
                oversize_sets++;
            end else if (cfg_algorithm == msel_pkg::ALG_SECURE_1ST && sec_valid) begin
                sel.found = 1'b1;
                sel.link  = sec_link;
                sel.score = sec_score[msel_pkg::SCORE_W-1:0];
            end else if (cfg_algorithm == msel_pkg::ALG_SECURE_1ST &&
                         cfg_policy == msel_pkg::POLICY_REQUIRED) begin
                // Security is mandatory and no secure link qualified.
                sel.found = 1'b0;
            end else if (run_valid) begin
                sel.found = 1'b1;
                sel.link  = run_link;
                sel.score = run_score[msel_pkg::SCORE_W-1:0];
            end
            pending_selections.push_back(sel);
            clear_running_best();
        end
    endfunction

    // Result monitor: every accepted selection is matched against the oldest
    // expected one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_selection(m_tdata);
    end

    task automatic check_selection(input logic [31:0] d);
        msel_pkg::res_t exp_sel;
        logic found;
        logic [3:0] link;
        logic signed [msel_pkg::SCORE_W-1:0] score;
        found = d[0];
        link  = d[4:1];
        score = d[26:5];
        if (pending_selections.size() == 0) begin
            $display("%0t: unexpected selection: expected none, actual found=%0b link=%0d",
                     $realtime, found, link);
            $display("%0t: unexpected selection score: expected none, actual %0d",
                     $realtime, score);
            mismatch_count++;
        end else begin
            exp_sel = pending_selections.pop_front();
            selections_checked++;
            if (exp_sel.found) selections_found++;
            if (found !== exp_sel.found) begin
                $display("%0t: found mismatch: expected %0b actual %0b",
                         $realtime, exp_sel.found, found);
                mismatch_count++;
            end
            if (link !== exp_sel.link) begin
                $display("%0t: chosen_link mismatch: expected %0d actual %0d",
                         $realtime, exp_sel.link, link);
                mismatch_count++;
            end
            if (score !== exp_sel.score) begin
                $display("%0t: chosen_score mismatch: expected %0d actual %0d",
                         $realtime, exp_sel.score, score);
                mismatch_count++;
            end
        end
    endtask

    function automatic link_rec_t make_record(
        input logic [3:0] id, input logic en, input logic [1:0] lstate, input logic meas,
        input logic sec, input logic [15:0] rtt, input logic [15:0] jit,
        input logic [9:0] loss, input logic signed [7:0] dbm, input logic last);
        link_rec_t r;
        r.id = id; r.en = en; r.lstate = lstate; r.meas = meas; r.sec = sec;
        r.rtt = rtt; r.jit = jit; r.loss = loss; r.dbm = dbm; r.last = last;
        return r;
    endfunction

    // Offers one record and returns at the edge where it is taken. s_tvalid is
    // left high so that a following record can go out back to back.
    task automatic send_link_record(input link_rec_t r);
        @(negedge aclk);
        s_tdata  = {5'b0, r.dbm, r.loss, r.jit, r.rtt, r.sec, r.meas, r.lstate, r.en, r.id};
        s_tlast  = r.last;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        records_sent++;
        track_link_record(r);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Drops the request, waits for every expected selection and then lets the
    // block finish any record that produces no output.
    task automatic wait_until_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_selections.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        settings_written++;
        unique case (idx)
            msel_pkg::REG_ALGORITHM: cfg_algorithm = value[1:0];
            msel_pkg::REG_POLICY:    cfg_policy    = value[1:0];
            msel_pkg::REG_RTT_THR:   cfg_rtt_thr   = value[15:0];
            msel_pkg::REG_JIT_THR:   cfg_jit_thr   = value[15:0];
            msel_pkg::REG_LOSS_THR:  cfg_loss_thr  = value[9:0];
            msel_pkg::REG_LIMITS:    cfg_limits    = value;
            msel_pkg::REG_WEIGHTS:   cfg_weights   = value[39:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] random_limit(input int hi);
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 15) return 16'd0;
        if (r < 25) return 16'hFFFF;
        return 16'($urandom_range(1, hi));
    endfunction

    function automatic logic [7:0] random_weight();
        int r;
        r = int'($urandom_range(0, 9));
        if (r == 0) return 8'd0;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic program_random_settings();
        logic [47:0] limits;
        logic [39:0] weights;
        int r;
        write_reg(msel_pkg::REG_ALGORITHM, 48'($urandom_range(0, 3)));
        write_reg(msel_pkg::REG_POLICY, 48'($urandom_range(0, 3)));
        r = int'($urandom_range(0, 9));
        write_reg(msel_pkg::REG_RTT_THR, (r < 2) ? 48'hFFFF : (r == 2) ? 48'd0 :
                  48'($urandom_range(0, 4000)));
        r = int'($urandom_range(0, 9));
        write_reg(msel_pkg::REG_JIT_THR, (r < 2) ? 48'hFFFF : (r == 2) ? 48'd0 :
                  48'($urandom_range(0, 600)));
        r = int'($urandom_range(0, 9));
        write_reg(msel_pkg::REG_LOSS_THR, (r < 2) ? 48'h3FF : (r == 2) ? 48'd0 :
                  48'($urandom_range(0, 1023)));
        limits  = {random_limit(1100), random_limit(700), random_limit(5000)};
        weights = {random_weight(), random_weight(), random_weight(), random_weight(),
                   random_weight()};
        write_reg(msel_pkg::REG_LIMITS, limits);
        write_reg(msel_pkg::REG_WEIGHTS, {8'd0, weights});
    endtask

    function automatic link_rec_t random_link_record(input logic last);
        link_rec_t r;
        int m;
        r.id     = 4'($urandom_range(0, 15));
        r.en     = ($urandom_range(0, 9) != 0);
        m        = int'($urandom_range(0, 9));
        r.lstate = (m < 6) ? msel_pkg::LINK_UP : (m < 8) ? msel_pkg::LINK_DEGRADED :
                   (m < 9) ? msel_pkg::LINK_DOWN : 2'd3;
        r.meas   = ($urandom_range(0, 9) != 0);
        r.sec    = 1'($urandom_range(0, 1));
        m        = int'($urandom_range(0, 9));
        r.rtt    = (m == 0) ? 16'd0 : (m == 1) ? 16'hFFFF :
                   (m < 6) ? 16'($urandom_range(0, 3000)) : 16'($urandom_range(0, 65535));
        m        = int'($urandom_range(0, 9));
        r.jit    = (m == 0) ? 16'hFFFF : (m < 7) ? 16'($urandom_range(0, 500)) :
                   16'($urandom_range(0, 65535));
        r.loss   = ($urandom_range(0, 9) < 3) ? 10'($urandom_range(0, 50)) :
                   10'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) != 0)
            r.dbm = 8'(int'($urandom_range(0, 70)) - 110);
        else
            r.dbm = 8'($urandom_range(0, 255));
        r.last   = last;
        return r;
    endfunction

    // One random set. Now and then a record repeats the previous metrics under
    // another id to make ties, and rarely the set is split by an idle pause in
    // which the algorithm or the policy changes.
    task automatic send_random_set();
        int len;
        int m;
        link_rec_t r;
        link_rec_t prev;
        m = int'($urandom_range(0, 99));
        if (m < 85)
            len = int'($urandom_range(1, 8));
        else if (m < 90)
            len = int'($urandom_range(8, 9));
        else
            len = int'($urandom_range(9, 12));
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 39) == 0) begin
                wait_until_idle();
                if ($urandom_range(0, 1) != 0)
                    write_reg(msel_pkg::REG_ALGORITHM, 48'($urandom_range(0, 3)));
                else
                    write_reg(msel_pkg::REG_POLICY, 48'($urandom_range(0, 3)));
            end
            if (i > 0 && $urandom_range(0, 6) == 0) begin
                r = prev;
                r.id = 4'($urandom_range(0, 15));
                r.last = (i == len - 1);
            end else begin
                r = random_link_record(i == len - 1);
            end
            send_link_record(r);
            prev = r;
            if (!no_idle) pause_sender(random_gap());
        end
    endtask

    // Right after reset the block runs the weighted mode with all weights zero,
    // so every eligible link scores 0 (or -500 degraded) and the first one wins.
    task automatic test_reset_defaults();
        send_link_record(make_record(4'd3, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd10, 16'd1,
                                     10'd1, 8'sd0, 1'b0));
        send_link_record(make_record(4'd5, 1'b1, msel_pkg::LINK_DEGRADED, 1'b1, 1'b1, 16'd0,
                                     16'd0, 10'd0, 8'sd0, 1'b1));
        wait_until_idle();
    endtask

    // Smallest round trip wins; a disabled link is skipped, link state
    // three counts as up, and the later of two equal round trips loses.
    task automatic test_lowest_rtt();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_LOWEST_RTT));
        write_reg(msel_pkg::REG_POLICY, 48'(msel_pkg::POLICY_OFF));
        write_reg(msel_pkg::REG_RTT_THR, 48'hFFFF);
        write_reg(msel_pkg::REG_JIT_THR, 48'hFFFF);
        write_reg(msel_pkg::REG_LOSS_THR, 48'h3FF);
        write_reg(msel_pkg::REG_LIMITS, 48'd0);
        write_reg(msel_pkg::REG_WEIGHTS, 48'd0);
        send_link_record(make_record(4'd1, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'hFFFF,
                                     16'd0, 10'd0, 8'sd0, 1'b0));
        send_link_record(make_record(4'd2, 1'b0, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd0, 16'd0,
                                     10'd0, 8'sd0, 1'b0));
        send_link_record(make_record(4'd7, 1'b1, 2'd3, 1'b1, 1'b0, 16'd0, 16'hFFFF, 10'd1023,
                                     -8'sd128, 1'b0));
        send_link_record(make_record(4'd9, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b1, 16'd0, 16'd0,
                                     10'd0, 8'sd127, 1'b1));
        wait_until_idle();
    endtask

    // Full weights and limits: the largest score, a degraded link, and the
    // signal clamp corners.
    task automatic test_weighted_extremes();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_WEIGHTED));
        write_reg(msel_pkg::REG_LIMITS, 48'hFFFF_FFFF_FFFF);
        write_reg(msel_pkg::REG_WEIGHTS, 48'hFF_FFFF_FFFF);
        send_link_record(make_record(4'd15, 1'b1, msel_pkg::LINK_DEGRADED, 1'b1, 1'b0,
                                     16'hFFFF, 16'hFFFF, 10'd1023, -8'sd128, 1'b0));
        send_link_record(make_record(4'd4, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd500,
                                     16'd20, 10'd3, -8'sd50, 1'b0));
        send_link_record(make_record(4'd5, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd500,
                                     16'd20, 10'd3, -8'sd51, 1'b0));
        send_link_record(make_record(4'd2, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b1, 16'd0, 16'd0,
                                     10'd0, 8'sd127, 1'b1));
        wait_until_idle();
    endtask

    // Required security with no secure link yields nothing; preferred falls back
    // to the plain weighted best.
    task automatic test_security_first();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_SECURE_1ST));
        write_reg(msel_pkg::REG_POLICY, 48'(msel_pkg::POLICY_REQUIRED));
        write_reg(msel_pkg::REG_WEIGHTS, 48'h01_0203_0405);
        send_link_record(make_record(4'd1, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd5, 16'd5,
                                     10'd5, -8'sd100, 1'b0));
        send_link_record(make_record(4'd2, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd9, 16'd9,
                                     10'd9, 8'sd0, 1'b1));
        wait_until_idle();
        write_reg(msel_pkg::REG_POLICY, 48'(msel_pkg::POLICY_PREFER));
        send_link_record(make_record(4'd6, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd30, 16'd3,
                                     10'd2, -8'sd99, 1'b1));
        wait_until_idle();
    endtask

    // Limits are inclusive: a link exactly at the threshold passes, one past it
    // is dropped even with a better score.
    task automatic test_threshold();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_THRESHOLD));
        write_reg(msel_pkg::REG_POLICY, 48'd3);
        write_reg(msel_pkg::REG_RTT_THR, 48'd100);
        write_reg(msel_pkg::REG_JIT_THR, 48'd0);
        write_reg(msel_pkg::REG_LOSS_THR, 48'd0);
        send_link_record(make_record(4'd1, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b0, 16'd100,
                                     16'd0, 10'd0, 8'sd0, 1'b0));
        send_link_record(make_record(4'd2, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b1, 16'd101,
                                     16'd0, 10'd0, 8'sd0, 1'b1));
        wait_until_idle();
    endtask

    // One record more than the block may track makes the set invalid.
    task automatic test_too_many_links();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_WEIGHTED));
        write_reg(msel_pkg::REG_POLICY, 48'(msel_pkg::POLICY_OFF));
        for (int i = 0; i <= MAX_LINKS; i++)
            send_link_record(make_record(4'(i), 1'b1, msel_pkg::LINK_UP, 1'b1, i[0],
                                         16'(i * 7), 16'(i), 10'(i), -8'sd60,
                                         i == MAX_LINKS));
        wait_until_idle();
    endtask

    // The algorithm changes between two records of one set while the block is
    // idle; the earlier record was tracked under the old mode.
    task automatic test_mid_set_change();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_LOWEST_RTT));
        send_link_record(make_record(4'd8, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b1, 16'd40, 16'd4,
                                     10'd4, 8'sd0, 1'b0));
        wait_until_idle();
        write_reg(msel_pkg::REG_ALGORITHM, 48'(msel_pkg::ALG_WEIGHTED));
        send_link_record(make_record(4'd11, 1'b1, msel_pkg::LINK_UP, 1'b1, 1'b1, 16'd20,
                                     16'd2, 10'd2, -8'sd70, 1'b1));
        wait_until_idle();
    endtask

    // The receiver holds off for a long stretch while short sets keep coming,
    // so the output register fills and the block stops taking records.
    task automatic test_output_stall();
        program_random_settings();
        rx_hold_len = 400;
        no_idle = 1'b1;
        repeat (4) begin
            send_link_record(random_link_record(1'b0));
            send_link_record(random_link_record(1'b1));
        end
        no_idle = 1'b0;
        wait_until_idle();
    endtask

    task automatic test_random_sets();
        int nsets;
        while (records_sent < ITEM_TARGET) begin
            wait_until_idle();
            program_random_settings();
            no_idle = ($urandom_range(0, 9) == 0);
            nsets = int'($urandom_range(2, 8));
            repeat (nsets) send_random_set();
        end
        no_idle = 1'b0;
        wait_until_idle();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rx_hold_len = 0;
        no_idle   = 1'b0;
        records_sent = 0;
        selections_checked = 0;
        selections_found = 0;
        oversize_sets = 0;
        settings_written = 0;
        mismatch_count = 0;
        cycle_count = 0;
        // Register defaults after reset.
        cfg_algorithm = msel_pkg::ALG_WEIGHTED;
        cfg_policy    = msel_pkg::POLICY_OFF;
        cfg_rtt_thr   = 16'hFFFF;
        cfg_jit_thr   = 16'hFFFF;
        cfg_loss_thr  = 10'h3FF;
        cfg_limits    = '0;
        cfg_weights   = '0;
        clear_running_best();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_lowest_rtt();
        test_weighted_extremes();
        test_security_first();
        test_threshold();
        test_too_many_links();
        test_mid_set_change();
        test_output_stall();
        test_random_sets();

        $display("Covered %0d link records in %0d sets (%0d with a link found, %0d oversize).",
                 records_sent, selections_checked, selections_found, oversize_sets);
        $display("Used %0d register writes over all four algorithms; %0d mismatches.",
                 settings_written, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
